// ===== src/u2d_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package u2d_pkg;

    localparam int BYTE_W = 8;
    localparam int UNIT_W = 16;
    localparam int CNT_OUT_W = 16;
    localparam int ACCUM_W = 21;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OUT_CAPACITY = 2'd0,
        REG_COUNT_ONLY   = 2'd1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    // restriction on the first continuation byte, set by the lead byte
    typedef enum logic [2:0] {
        LC_NONE = 3'd0,
        LC_E0   = 3'd1,
        LC_ED   = 3'd2,
        LC_F0   = 3'd3,
        LC_F4   = 3'd4
    } t_lead_class;

    typedef struct packed {
        logic [ACCUM_W-1:0] accum;
        logic [1:0]         bytes_left;
        logic [2:0]         seq_length;
        t_lead_class        lead_class;
        logic               first_pending;
        t_status            err;
    } t_seq_state;

    typedef struct packed {
        logic              unit_valid;
        logic [UNIT_W-1:0] code_unit;
        logic              done_res;
        t_status           status;
        logic [CNT_OUT_W-1:0] unit_count;
        logic [CNT_OUT_W-1:0] skipped_bytes;
    } t_result;

    localparam t_seq_state SEQ_IDLE = '{
        accum:         '0,
        bytes_left:    2'd0,
        seq_length:    3'd0,
        lead_class:    LC_NONE,
        first_pending: 1'b0,
        err:           ST_OK
    };

endpackage

`default_nettype wire

// ===== src/u2d_ifs.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface u2d_in_if;
    logic                      valid;
    logic                      ready;
    logic [u2d_pkg::BYTE_W-1:0] in_byte;
    logic                      last;

    modport source (output valid, output in_byte, output last, input ready);
    modport sink   (input valid, input in_byte, input last, output ready);
endinterface

interface u2d_out_if;
    logic                         valid;
    logic                         ready;
    logic                         unit_valid;
    logic [u2d_pkg::UNIT_W-1:0]    code_unit;
    logic                         done_res;
    logic [1:0]                   status;
    logic [u2d_pkg::CNT_OUT_W-1:0] unit_count;
    logic [u2d_pkg::CNT_OUT_W-1:0] skipped_bytes;

    modport source (output valid, output unit_valid, output code_unit, output done_res,
                    output status, output unit_count, output skipped_bytes, input ready);
    modport sink   (input valid, input unit_valid, input code_unit, input done_res,
                    input status, input unit_count, input skipped_bytes, output ready);
endinterface

interface u2d_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [u2d_pkg::CFG_IDX_W-1:0]  index;
    logic [u2d_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/u2d_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

module u2d_step #(
    parameter int CW = 16
) (
    input  wire u2d_pkg::t_seq_state          i_state,
    input  wire logic [CW-1:0]                i_units,
    input  wire logic [CW-1:0]                i_skipped,
    input  wire logic [u2d_pkg::BYTE_W-1:0]   i_byte,
    input  wire logic                         i_last,
    input  wire logic [u2d_pkg::UNIT_W-1:0]   i_out_capacity,
    input  wire logic                         i_count_only,
    output u2d_pkg::t_seq_state               o_state,
    output logic [CW-1:0]                     o_units,
    output logic [CW-1:0]                     o_skipped,
    output u2d_pkg::t_result                  o_result,
    output logic                              o_has_result
);

    logic                               have_cp;
    logic                               emitted;
    logic [u2d_pkg::ACCUM_W-1:0]        cp;
    logic [u2d_pkg::ACCUM_W-1:0]        accum_next;
    logic [u2d_pkg::BYTE_W-1:0]         lo;
    logic [u2d_pkg::BYTE_W-1:0]         hi;
    logic [CW:0]                        skip_sum;
    logic [CW:0]                        unit_sum;

    assign accum_next = {i_state.accum[u2d_pkg::ACCUM_W-7:0], i_byte[5:0]};
    assign skip_sum   = {1'b0, i_skipped} + (CW+1)'(i_state.seq_length);
    assign unit_sum   = {1'b0, i_units} + (CW+1)'(1);

    // continuation range, narrowed for overlong, surrogate and above-range forms
    always_comb begin
        lo = 8'h80;
        hi = 8'hBF;
        if (i_state.first_pending) begin
            case (i_state.lead_class)
                u2d_pkg::LC_E0: lo = 8'hA0;
                u2d_pkg::LC_ED: hi = 8'h9F;
                u2d_pkg::LC_F0: lo = 8'h90;
                u2d_pkg::LC_F4: hi = 8'h8F;
                default: ;
            endcase
        end
    end

    always_comb begin
        o_state   = i_state;
        o_units   = i_units;
        o_skipped = i_skipped;
        have_cp   = 1'b0;
        emitted   = 1'b0;
        cp        = '0;

        if (i_state.err == u2d_pkg::ST_OK) begin
            if (i_state.bytes_left == 2'd0) begin
                case (i_byte) inside
                    [8'h00:8'h7F]: begin
                        cp      = u2d_pkg::ACCUM_W'(i_byte);
                        have_cp = 1'b1;
                    end
                    [8'hC2:8'hDF]: begin
                        o_state.accum         = u2d_pkg::ACCUM_W'(i_byte[4:0]);
                        o_state.bytes_left    = 2'd1;
                        o_state.seq_length    = 3'd2;
                        o_state.lead_class    = u2d_pkg::LC_NONE;
                        o_state.first_pending = 1'b1;
                    end
                    [8'hE0:8'hEF]: begin
                        o_state.accum         = u2d_pkg::ACCUM_W'(i_byte[3:0]);
                        o_state.bytes_left    = 2'd2;
                        o_state.seq_length    = 3'd3;
                        o_state.lead_class    = (i_byte == 8'hE0) ? u2d_pkg::LC_E0 :
                                                (i_byte == 8'hED) ? u2d_pkg::LC_ED :
                                                                    u2d_pkg::LC_NONE;
                        o_state.first_pending = 1'b1;
                    end
                    [8'hF0:8'hF4]: begin
                        o_state.accum         = u2d_pkg::ACCUM_W'(i_byte[2:0]);
                        o_state.bytes_left    = 2'd3;
                        o_state.seq_length    = 3'd4;
                        o_state.lead_class    = (i_byte == 8'hF0) ? u2d_pkg::LC_F0 :
                                                (i_byte == 8'hF4) ? u2d_pkg::LC_F4 :
                                                                    u2d_pkg::LC_NONE;
                        o_state.first_pending = 1'b1;
                    end
                    default: o_state.err = u2d_pkg::ST_INVALID;
                endcase
            end else if (i_byte < lo || i_byte > hi) begin
                o_state.err = u2d_pkg::ST_INVALID;
            end else begin
                o_state.accum         = accum_next;
                o_state.bytes_left    = i_state.bytes_left - 2'd1;
                o_state.first_pending = 1'b0;
                if (i_state.bytes_left == 2'd1) begin
                    if (accum_next[u2d_pkg::ACCUM_W-1:u2d_pkg::UNIT_W] == '0) begin
                        cp      = accum_next;
                        have_cp = 1'b1;
                    end else begin
                        o_skipped = skip_sum[CW] ? '1 : skip_sum[CW-1:0];
                    end
                end
            end

            if (have_cp) begin
                if (!i_count_only && (u2d_pkg::UNIT_W'(i_units) >= i_out_capacity)) begin
                    o_state.err = u2d_pkg::ST_OVERFLOW;
                end else begin
                    emitted = 1'b1;
                    o_units = unit_sum[CW] ? '1 : unit_sum[CW-1:0];
                end
            end
        end

        // truncated sequence at end of string
        if (i_last && o_state.err == u2d_pkg::ST_OK && o_state.bytes_left != 2'd0) begin
            o_state.err = u2d_pkg::ST_INVALID;
        end
    end

    always_comb begin
        o_result.unit_valid    = emitted;
        o_result.code_unit     = emitted ? cp[u2d_pkg::UNIT_W-1:0] : '0;
        o_result.done_res      = i_last;
        o_result.status        = o_state.err;
        o_result.unit_count    = u2d_pkg::CNT_OUT_W'(o_units);
        o_result.skipped_bytes = u2d_pkg::CNT_OUT_W'(o_skipped);
        o_has_result           = emitted || i_last;
    end

endmodule

`default_nettype wire

// ===== src/utf8_to_ucs2_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Strict UTF-8 to UCS-2 decoder. One byte is taken per request on i_in, with
// last marking the end of a string; a result leaves on o_out for every decoded
// basic-plane unit and for the last byte, which carries the final status and
// counts. The block sustains one byte per clock cycle while o_out takes its
// results: a byte is registered, decoded by a single level of logic against the
// sequence state, and the result lands in an output register once that register
// is free or being taken. Input is held off only while the input register holds
// a byte and the output register is full and not taken. Sequence state and
// counts clear after each last byte. The user must write out_capacity and
// count_only on i_cfg while no string is in flight; the block does not enforce it.
module utf8_to_ucs2_decoder #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    u2d_cfg_if.sink     i_cfg,
    u2d_in_if.sink      i_in,
    u2d_out_if.source   o_out
);

    localparam int CW = (COUNT_BITS < u2d_pkg::CNT_OUT_W) ? COUNT_BITS : u2d_pkg::CNT_OUT_W;

    logic [u2d_pkg::UNIT_W-1:0]  r_out_capacity;
    logic                        r_count_only;

    logic                        r_in_valid;
    logic [u2d_pkg::BYTE_W-1:0]  r_in_byte;
    logic                        r_in_last;

    u2d_pkg::t_seq_state         r_state;
    logic [CW-1:0]               r_units;
    logic [CW-1:0]               r_skipped;

    logic                        r_out_valid;
    u2d_pkg::t_result            r_result;

    u2d_pkg::t_seq_state         n_state;
    logic [CW-1:0]               n_units;
    logic [CW-1:0]               n_skipped;
    u2d_pkg::t_result            n_result;
    logic                        n_has_result;

    logic                        advance;

    assign advance     = !r_out_valid || o_out.ready;
    assign i_in.ready  = !r_in_valid || advance;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_capacity <= 16'hFFFF;
            r_count_only   <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                u2d_pkg::REG_OUT_CAPACITY: r_out_capacity <= i_cfg.data;
                u2d_pkg::REG_COUNT_ONLY:   r_count_only   <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    u2d_step #(
        .CW (CW)
    ) u_step (
        .i_state        (r_state),
        .i_units        (r_units),
        .i_skipped      (r_skipped),
        .i_byte         (r_in_byte),
        .i_last         (r_in_last),
        .i_out_capacity (r_out_capacity),
        .i_count_only   (r_count_only),
        .o_state        (n_state),
        .o_units        (n_units),
        .o_skipped      (n_skipped),
        .o_result       (n_result),
        .o_has_result   (n_has_result)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.in_byte;
            r_in_last <= i_in.last;
        end
    end

    // sequence state, committed when the registered byte is consumed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= u2d_pkg::SEQ_IDLE;
            r_units   <= '0;
            r_skipped <= '0;
        end else if (r_in_valid && advance) begin
            if (r_in_last) begin
                r_state   <= u2d_pkg::SEQ_IDLE;
                r_units   <= '0;
                r_skipped <= '0;
            end else begin
                r_state   <= n_state;
                r_units   <= n_units;
                r_skipped <= n_skipped;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid && n_has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid && n_has_result) begin
            r_result <= n_result;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.unit_valid    = r_result.unit_valid;
    assign o_out.code_unit     = r_result.code_unit;
    assign o_out.done_res      = r_result.done_res;
    assign o_out.status        = r_result.status;
    assign o_out.unit_count    = r_result.unit_count;
    assign o_out.skipped_bytes = r_result.skipped_bytes;

endmodule

`default_nettype wire

// ===== sim/tb_utf8_to_ucs2_decoder.sv =====
`timescale 1ns / 1ps

module tb_utf8_to_ucs2_decoder;
    import u2d_pkg::*;

    localparam int HALF_PERIOD = 2;
    localparam int RANDOM_BYTES = 750;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 3000;
    localparam int MAX_PRINTS = 20;
    localparam logic [CNT_OUT_W-1:0] CNT_MAX = 16'hFFFF;
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_3 = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              last;
    } t_byte_req;

    typedef enum {
        CH_ASCII, CH_TWO, CH_THREE, CH_FOUR, CH_BAD_LEAD, CH_BAD_CONT, CH_CUT
    } t_char_kind;

    typedef enum {RX_FREE, RX_BUSY, RX_HALF, RX_SLOW} t_rx_mode;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    u2d_cfg_if cfg_if ();
    u2d_in_if  byte_if ();
    u2d_out_if unit_if ();

    utf8_to_ucs2_decoder u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (byte_if),
        .o_out   (unit_if)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // decoder shadow: sequence state, counts and register copies
    t_seq_state           dec_state = SEQ_IDLE;
    logic [CNT_OUT_W-1:0] units_cnt = '0;
    logic [CNT_OUT_W-1:0] skipped_cnt = '0;
    logic [UNIT_W-1:0]    out_cap = 16'hFFFF;
    logic                 only_count = 1'b0;

    t_byte_req  byte_queue[$];
    t_result    due_results[$];
    t_byte_req  cur_req = '0;
    bit         byte_offered = 1'b0;
    int         burst_left = 0;
    int         gap_left = 0;

    logic [BYTE_W-1:0] str_bytes[$];
    int         str_units = 0;
    bit         str_spoiled = 1'b0;
    int         useful_bytes = 0;
    int         sent_bytes = 0;

    t_rx_mode   rx_mode = RX_FREE;
    int         mode_left = 0;
    int         hold_left = 0;
    bit         hold_done = 1'b0;
    int         results_seen = 0;
    int         mismatch_count = 0;
    int         quiet_cycles = 0;

    function automatic bit decode_byte(input logic [BYTE_W-1:0] b, input logic is_last,
                                       output t_result res);
        logic [BYTE_W-1:0] lo;
        logic [BYTE_W-1:0] hi;
        logic [UNIT_W-1:0] cp;
        logic [16:0]       sum;
        bit                have_cp;
        bit                emitted;
        have_cp = 1'b0;
        emitted = 1'b0;
        cp = '0;
        res = '0;
        if (dec_state.err == ST_OK) begin
            if (dec_state.bytes_left == 2'd0) begin
                if (b < 8'h80) begin
                    cp = {8'h00, b};
                    have_cp = 1'b1;
                end else if (b >= 8'hC2 && b <= 8'hDF) begin
                    dec_state.accum = {16'd0, b[4:0]};
                    dec_state.bytes_left = 2'd1;
                    dec_state.seq_length = 3'd2;
                    dec_state.lead_class = LC_NONE;
                    dec_state.first_pending = 1'b1;
                end else if (b >= 8'hE0 && b <= 8'hEF) begin
                    dec_state.accum = {17'd0, b[3:0]};
                    dec_state.bytes_left = 2'd2;
                    dec_state.seq_length = 3'd3;
                    dec_state.lead_class = (b == 8'hE0) ? LC_E0 : (b == 8'hED) ? LC_ED : LC_NONE;
                    dec_state.first_pending = 1'b1;
                end else if (b >= 8'hF0 && b <= 8'hF4) begin
                    dec_state.accum = {18'd0, b[2:0]};
                    dec_state.bytes_left = 2'd3;
                    dec_state.seq_length = 3'd4;
                    dec_state.lead_class = (b == 8'hF0) ? LC_F0 : (b == 8'hF4) ? LC_F4 : LC_NONE;
                    dec_state.first_pending = 1'b1;
                end else begin
                    dec_state.err = ST_INVALID;
                end
            end else begin
                lo = 8'h80;
                hi = 8'hBF;
                // the lead byte narrows only the first continuation byte
                if (dec_state.first_pending) begin
                    case (dec_state.lead_class)
                        LC_E0:   lo = 8'hA0;
                        LC_ED:   hi = 8'h9F;
                        LC_F0:   lo = 8'h90;
                        LC_F4:   hi = 8'h8F;
                        default: ;
                    endcase
                end
                if (b < lo || b > hi) begin
                    dec_state.err = ST_INVALID;
                end else begin
                    dec_state.accum = {dec_state.accum[ACCUM_W-7:0], b[5:0]};
                    dec_state.bytes_left = dec_state.bytes_left - 2'd1;
                    dec_state.first_pending = 1'b0;
                    if (dec_state.bytes_left == 2'd0) begin
                        if (dec_state.accum <= 21'h00FFFF) begin
                            cp = dec_state.accum[UNIT_W-1:0];
                            have_cp = 1'b1;
                        end else begin
                            sum = {1'b0, skipped_cnt} + {14'd0, dec_state.seq_length};
                            skipped_cnt = sum[16] ? CNT_MAX : sum[15:0];
                        end
                    end
                end
            end
            if (have_cp) begin
                if (!only_count && units_cnt >= out_cap) begin
                    dec_state.err = ST_OVERFLOW;
                end else begin
                    emitted = 1'b1;
                    if (units_cnt != CNT_MAX) units_cnt = units_cnt + 16'd1;
                end
            end
        end
        if (is_last && dec_state.err == ST_OK && dec_state.bytes_left != 2'd0) begin
            dec_state.err = ST_INVALID;
        end
        if (!emitted && !is_last) return 1'b0;
        res.unit_valid = emitted;
        res.code_unit = emitted ? cp : '0;
        res.done_res = is_last;
        res.status = dec_state.err;
        res.unit_count = units_cnt;
        res.skipped_bytes = skipped_cnt;
        if (is_last) begin
            dec_state = SEQ_IDLE;
            units_cnt = '0;
            skipped_cnt = '0;
        end
        return 1'b1;
    endfunction

    function automatic logic [BYTE_W-1:0] rand_byte(input logic [BYTE_W-1:0] lo,
                                                    input logic [BYTE_W-1:0] hi);
        return BYTE_W'($urandom_range(int'(hi), int'(lo)));
    endfunction

    // {low, high} bound of the first continuation byte after a lead
    function automatic logic [15:0] first_cont_range(input logic [BYTE_W-1:0] lead);
        case (lead)
            8'hE0:   return 16'hA0BF;
            8'hED:   return 16'h809F;
            8'hF0:   return 16'h90BF;
            8'hF4:   return 16'h808F;
            default: return 16'h80BF;
        endcase
    endfunction

    function automatic void add_char(input t_char_kind kind);
        logic [BYTE_W-1:0] lead;
        logic [15:0]       first_rng;
        int                seq_len;
        int                n_good;
        int                start_size;
        start_size = str_bytes.size();
        case (kind)
            CH_ASCII: lead = rand_byte(8'h00, 8'h7F);
            CH_TWO:   lead = rand_byte(8'hC2, 8'hDF);
            CH_THREE: begin
                if ($urandom_range(2) == 0) lead = ($urandom_range(1) == 0) ? 8'hE0 : 8'hED;
                else lead = rand_byte(8'hE0, 8'hEF);
            end
            CH_FOUR: begin
                if ($urandom_range(2) == 0) lead = ($urandom_range(1) == 0) ? 8'hF0 : 8'hF4;
                else lead = rand_byte(8'hF0, 8'hF4);
            end
            CH_BAD_LEAD: begin
                case ($urandom_range(2))
                    0:       lead = rand_byte(8'h80, 8'hBF);
                    1:       lead = rand_byte(8'hC0, 8'hC1);
                    default: lead = rand_byte(8'hF5, 8'hFF);
                endcase
            end
            default: lead = rand_byte(8'hC2, 8'hF4);
        endcase
        if (lead < 8'h80 || kind == CH_BAD_LEAD) seq_len = 1;
        else if (lead < 8'hE0) seq_len = 2;
        else if (lead < 8'hF0) seq_len = 3;
        else seq_len = 4;
        first_rng = first_cont_range(lead);
        n_good = seq_len - 1;
        if (kind == CH_BAD_CONT || kind == CH_CUT) n_good = $urandom_range(seq_len - 2);
        str_bytes.push_back(lead);
        for (int i = 0; i < n_good; i++) begin
            if (i == 0) str_bytes.push_back(rand_byte(first_rng[15:8], first_rng[7:0]));
            else str_bytes.push_back(rand_byte(8'h80, 8'hBF));
        end
        if (kind == CH_BAD_CONT) begin
            // either just outside the narrowed range or not a continuation byte at all
            if (n_good == 0 && first_rng != 16'h80BF && $urandom_range(1) == 0) begin
                if (first_rng[15:8] != 8'h80)
                    str_bytes.push_back(rand_byte(8'h80, first_rng[15:8] - 8'd1));
                else
                    str_bytes.push_back(rand_byte(first_rng[7:0] + 8'd1, 8'hBF));
            end else if ($urandom_range(1) == 0) begin
                str_bytes.push_back(rand_byte(8'h00, 8'h7F));
            end else begin
                str_bytes.push_back(rand_byte(8'hC0, 8'hFF));
            end
        end
        if (!str_spoiled) useful_bytes += str_bytes.size() - start_size;
        if (kind == CH_ASCII || kind == CH_TWO || kind == CH_THREE) begin
            str_units++;
            if (!only_count && str_units > int'(out_cap)) str_spoiled = 1'b1;
        end else if (kind != CH_FOUR) begin
            str_spoiled = 1'b1;
        end
    endfunction

    function automatic void send_string();
        foreach (str_bytes[i]) begin
            byte_queue.push_back(t_byte_req'{value: str_bytes[i],
                                             last: (i == str_bytes.size() - 1)});
        end
        sent_bytes += str_bytes.size();
        str_bytes.delete();
        str_units = 0;
        str_spoiled = 1'b0;
    endfunction

    function automatic void queue_random_string(input int n_chars, input bit clean,
                                                input bit cut_end);
        int         pick;
        t_char_kind kind;
        for (int k = 0; k < n_chars; k++) begin
            pick = $urandom_range(clean ? 86 : 99);
            if (pick < 35) kind = CH_ASCII;
            else if (pick < 55) kind = CH_TWO;
            else if (pick < 75) kind = CH_THREE;
            else if (pick < 87) kind = CH_FOUR;
            else if (pick < 91) kind = CH_BAD_LEAD;
            else if (pick < 96) kind = CH_BAD_CONT;
            else kind = CH_CUT;
            add_char(kind);
        end
        if (cut_end) add_char(CH_CUT);
        send_string();
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= val;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        cfg_if.valid <= 1'b0;
        case (idx)
            REG_OUT_CAPACITY: out_cap = val;
            REG_COUNT_ONLY:   only_count = val[0];
            default:          ;
        endcase
    endtask

    task automatic wait_drained();
        while (byte_queue.size() != 0 || byte_offered || due_results.size() != 0)
            @(posedge i_clk);
        // bytes that make no result may still be in the pipe
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (mismatch_count < MAX_PRINTS)
            $display("%0t ns: %s mismatch, got %0h want %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // byte sender: bursts of requests separated by random gaps
    always @(posedge i_clk) begin : byte_driver
        t_result res;
        int      pick;
        if (!i_rst_n) begin
            byte_if.valid <= 1'b0;
        end else begin
            if (byte_if.valid && byte_if.ready) begin
                if (decode_byte(cur_req.value, cur_req.last, res)) due_results.push_back(res);
                byte_offered = 1'b0;
            end
            if (!byte_offered) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (byte_queue.size() != 0) begin
                    cur_req = byte_queue.pop_front();
                    byte_offered = 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(40, 1);
                        pick = $urandom_range(99);
                        if (pick < 40) gap_left = 0;
                        else if (pick < 85) gap_left = $urandom_range(4, 1);
                        else if (pick < 98) gap_left = $urandom_range(20, 5);
                        else gap_left = $urandom_range(60, 30);
                    end
                end
            end
            byte_if.valid <= byte_offered;
            byte_if.in_byte <= cur_req.value;
            byte_if.last <= cur_req.last;
        end
    end

    always @(posedge i_clk) begin : unit_monitor
        t_result got;
        t_result want;
        logic    take;
        if (!i_rst_n) begin
            unit_if.ready <= 1'b0;
        end else begin
            if (unit_if.valid && unit_if.ready) begin
                got.unit_valid = unit_if.unit_valid;
                got.code_unit = unit_if.code_unit;
                got.done_res = unit_if.done_res;
                got.status = t_status'(unit_if.status);
                got.unit_count = unit_if.unit_count;
                got.skipped_bytes = unit_if.skipped_bytes;
                results_seen++;
                if (due_results.size() == 0) begin
                    flag_mismatch("unexpected result", 32'(got.code_unit), 32'd0);
                end else begin
                    want = due_results.pop_front();
                    if (got.unit_valid !== want.unit_valid)
                        flag_mismatch("unit_valid", 32'(got.unit_valid), 32'(want.unit_valid));
                    if (got.code_unit !== want.code_unit)
                        flag_mismatch("code_unit", 32'(got.code_unit), 32'(want.code_unit));
                    if (got.done_res !== want.done_res)
                        flag_mismatch("done_res", 32'(got.done_res), 32'(want.done_res));
                    if (got.status !== want.status)
                        flag_mismatch("status", 32'(got.status), 32'(want.status));
                    if (got.unit_count !== want.unit_count)
                        flag_mismatch("unit_count", 32'(got.unit_count), 32'(want.unit_count));
                    if (got.skipped_bytes !== want.skipped_bytes)
                        flag_mismatch("skipped_bytes", 32'(got.skipped_bytes),
                                      32'(want.skipped_bytes));
                end
            end
            // one long hold-off while requests keep coming, so the input backs up
            if (hold_left != 0) begin
                hold_left--;
            end else if (!hold_done && results_seen >= 60 && byte_queue.size() > 20) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (mode_left != 0) begin
                mode_left--;
            end else begin
                rx_mode = t_rx_mode'($urandom_range(3));
                mode_left = $urandom_range(160, 8);
            end
            case (rx_mode)
                RX_FREE: take = 1'b1;
                RX_BUSY: take = ($urandom_range(3) != 0);
                RX_HALF: take = ($urandom_range(1) != 0);
                default: take = ($urandom_range(7) == 0);
            endcase
            unit_if.ready <= take && (hold_left == 0);
        end
    end

    always @(posedge i_clk) begin : watchdog
        if ((byte_if.valid && byte_if.ready) || (unit_if.valid && unit_if.ready)
                || (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [CFG_DATA_W-1:0] cap_val;
        logic [CFG_DATA_W-1:0] mode_word;
        int                    phase_goal;
        int                    n_str;
        byte_if.valid = 1'b0;
        byte_if.in_byte = '0;
        byte_if.last = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.data = '0;
        unit_if.ready = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: boundary code points, overflow with sticky ignore, bad first
        // continuation, truncation at the last byte, stray continuation as lead
        write_reg(REG_OUT_CAPACITY, 16'd3);
        write_reg(REG_COUNT_ONLY, 16'hFFFE);
        str_bytes = '{8'h00, 8'hC2, 8'h80, 8'hF0, 8'h90, 8'h80, 8'h80, 8'hEF, 8'hBF,
                      8'hBF, 8'h7F, 8'hC0, 8'h41};
        send_string();
        str_bytes = '{8'hE0, 8'h9F};
        send_string();
        str_bytes = '{8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'hED, 8'h9F, 8'hBF, 8'hE0, 8'hA0};
        send_string();
        str_bytes = '{8'h80};
        send_string();
        wait_drained();

        for (int ph = 0; sent_bytes < RANDOM_BYTES; ph++) begin
            case (ph)
                0: cap_val = 16'd0;
                1: cap_val = 16'hFFFF;
                default: begin
                    case ($urandom_range(4))
                        0:       cap_val = 16'd0;
                        1:       cap_val = 16'($urandom_range(3, 1));
                        2:       cap_val = 16'($urandom_range(20, 4));
                        3:       cap_val = 16'hFFFF;
                        default: cap_val = 16'($urandom_range(16'hFFFF));
                    endcase
                end
            endcase
            mode_word = 16'($urandom_range(16'hFFFF));
            if (ph == 0) mode_word[0] = 1'b0;
            else if (ph == 1) mode_word[0] = 1'b1;
            else mode_word[0] = ($urandom_range(3) == 0);
            write_reg(REG_OUT_CAPACITY, cap_val);
            write_reg(REG_COUNT_ONLY, mode_word);
            if (ph % 4 == 3) begin
                write_reg(IDX_SPARE_2, 16'($urandom_range(16'hFFFF)));
                write_reg(IDX_SPARE_3, 16'($urandom_range(16'hFFFF)));
            end
            phase_goal = useful_bytes + 90;
            n_str = 0;
            while (useful_bytes < phase_goal && n_str < 30) begin
                queue_random_string($urandom_range(($urandom_range(9) == 0) ? 30 : 8, 1),
                                    (ph % 3 == 2), ($urandom_range(11) == 0));
                n_str++;
            end
            wait_drained();
        end

        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
